// ===== design/cpba_pkg.sv =====
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Shared widths, page mark codes and status codes of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpba_pkg;

    localparam int PAGES_DEF      = 4096;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int WORD_PAGES     = 16;
    localparam int WPI_W          = 4;
    localparam int MARK_W         = 2;
    localparam int WORD_W         = WORD_PAGES * MARK_W;
    localparam int LIMIT_W        = 9;
    localparam int COUNT_W        = 13;
    localparam int ADDR_W         = 32;
    localparam int STATUS_W       = 2;
    localparam int IN_DATA_W      = 80;
    localparam int OUT_DATA_W     = 48;

    typedef logic [MARK_W-1:0] t_mark;

    localparam t_mark MARK_FREE   = 2'b00;
    localparam t_mark MARK_FIRST  = 2'b01;
    localparam t_mark MARK_INSIDE = 2'b10;
    localparam t_mark MARK_LAST   = 2'b11;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOSPACE = 2'd1;
    localparam t_status ST_BADPTR  = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

`default_nettype wire

// ===== design/cpba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cpba_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]                   i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [DATA_W-1:0]                   o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/contiguous_page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator
// Next-fit allocator of contiguous page runs over a store of 2-bit page marks.
// ----------------------------------------------------------------------------
// Each input beat on the s_axis channel is one request: tuser selects allocate
// or free, tdata carries page_count, heap_base and free_address. Each request
// gives exactly one m_axis beat: tuser holds the status, tdata the run address
// and the number of freed pages. The cfg channel writes limit_words; it is
// always ready. It must be written only while no request is in flight; the
// block itself does not enforce this. The marks sit in one RAM of PAGES/16
// words, 16 pages per word, with registered read data. Every word access is
// a read state followed by an evaluate or write state. A zero count, an
// exhausted search range or a pointer beyond the store finishes without
// reading the store; a pointer whose marks do not name the first page of a
// run finishes after the check of its word and, if needed, the word before.
// After reset the block clears all PAGES/16 words of the RAM, one word per
// cycle, and accepts no request meanwhile. A finished result is held in the
// output register while the receiver stalls; the next request is accepted
// in the meantime and waits for the register to drain before it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_page_bitmap_allocator #(
    parameter int PAGES      = cpba_pkg::PAGES_DEF,
    parameter int PAGE_SHIFT = cpba_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request channel.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // page_count [12:0], heap_base [44:13], free_address [76:45], zero [79:77]
    input  wire logic [cpba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [0]
    input  wire logic                            s_axis_tuser,
    // Result channel.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // run_address [31:0], freed_count [44:32], zero [47:45]
    output logic      [cpba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic      [cpba_pkg::STATUS_W-1:0]   m_axis_tuser,
    // Configuration channel (limit_words).
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cpba_pkg::LIMIT_W-1:0]    i_cfg_data
);

    localparam int WORDS = PAGES / cpba_pkg::WORD_PAGES;
    localparam int STORE_PAGES = WORDS * cpba_pkg::WORD_PAGES;
    localparam int WA_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RW_W = $clog2(WORDS + 1);
    localparam int PG_W = WA_W + cpba_pkg::WPI_W;
    localparam int RUN_W = cpba_pkg::COUNT_W + 1;
    localparam int WP = cpba_pkg::WORD_PAGES;
    localparam int MW = cpba_pkg::MARK_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_M_RD,
        S_M_WR,
        S_F_RD0,
        S_F_CHK,
        S_F_PRD,
        S_F_PEV,
        S_F_RD,
        S_F_WR,
        S_PUSH
    } t_state;

    t_state                          r_state, n_state;
    logic [RW_W-1:0]                 r_w, n_w;
    logic [RW_W-1:0]                 r_end, n_end;
    logic [RW_W-1:0]                 r_resume, n_resume;
    logic [cpba_pkg::LIMIT_W-1:0]    r_limit, n_limit;
    logic [RUN_W-1:0]                r_run, n_run;
    logic [cpba_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [cpba_pkg::ADDR_W-1:0]     r_base, n_base;
    logic [PG_W-1:0]                 r_start, n_start;
    logic [PG_W-1:0]                 r_last, n_last;
    logic [PG_W-1:0]                 r_pg, n_pg;
    logic [cpba_pkg::WPI_W-1:0]      r_fo, n_fo;
    logic [cpba_pkg::COUNT_W-1:0]    r_freed, n_freed;
    cpba_pkg::t_status               r_res_st, n_res_st;
    logic [cpba_pkg::ADDR_W-1:0]     r_res_addr, n_res_addr;
    logic [cpba_pkg::COUNT_W-1:0]    r_res_freed, n_res_freed;
    logic                            r_m_valid, n_m_valid;
    cpba_pkg::t_status               r_m_st, n_m_st;
    logic [cpba_pkg::ADDR_W-1:0]     r_m_addr, n_m_addr;
    logic [cpba_pkg::COUNT_W-1:0]    r_m_freed, n_m_freed;

    logic                            ram_we;
    logic [cpba_pkg::WORD_W-1:0]     ram_wdata;
    logic [cpba_pkg::WORD_W-1:0]     ram_rdata;

    logic                            lim_big;
    logic [RW_W-1:0]                 a_end;
    logic                            a_free;
    logic [cpba_pkg::WPI_W:0]        a_blk;
    logic [RUN_W-1:0]                a_run;
    logic                            a_hit;
    logic [cpba_pkg::WPI_W-1:0]      a_pos;
    logic [PG_W-1:0]                 q_pg;
    cpba_pkg::t_mark                 q_mark;
    logic [cpba_pkg::WORD_W-1:0]     mk_word;
    logic                            f_found;
    logic [cpba_pkg::WPI_W-1:0]      f_pos;
    logic [cpba_pkg::WPI_W:0]        f_add;
    logic [cpba_pkg::WORD_W-1:0]     fw_word;
    logic [cpba_pkg::ADDR_W-1:0]     f_off;
    logic [cpba_pkg::ADDR_W-1:0]     f_idx;
    cpba_pkg::t_mark                 f_mark;
    cpba_pkg::t_mark                 f_prev;
    logic [cpba_pkg::WPI_W-1:0]      fo_m1;

    cpba_ram #(
        .DATA_W (cpba_pkg::WORD_W),
        .DEPTH  (WORDS)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_w[WA_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_w[WA_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_st;
    assign m_axis_tdata  = {3'b000, r_m_freed, r_m_addr};

    // Word evaluation for the allocate scan, run marking and free walk.
    always_comb begin
        a_blk = '0;
        a_run = '0;
        a_hit = 1'b0;
        a_pos = '0;
        for (int i = 0; i < WP; i++) begin
            a_free = (ram_rdata[MW*i +: MW] == cpba_pkg::MARK_FREE);
            if (!a_free) begin
                a_blk = (cpba_pkg::WPI_W + 1)'(i + 1);
            end
            if (a_blk == '0) begin
                a_run = r_run + RUN_W'(i + 1);
            end else begin
                a_run = RUN_W'(i + 1) - RUN_W'(a_blk);
            end
            if (a_free && !a_hit && a_run == {1'b0, r_count}) begin
                a_hit = 1'b1;
                a_pos = cpba_pkg::WPI_W'(i);
            end
        end

        for (int i = 0; i < WP; i++) begin
            q_pg = {r_w[WA_W-1:0], cpba_pkg::WPI_W'(i)};
            q_mark = ram_rdata[MW*i +: MW];
            if (q_pg >= r_start && q_pg <= r_last) begin
                if (q_pg == r_last) begin
                    q_mark = cpba_pkg::MARK_LAST;
                end else if (q_pg == r_start) begin
                    q_mark = cpba_pkg::MARK_FIRST;
                end else begin
                    q_mark = cpba_pkg::MARK_INSIDE;
                end
            end
            mk_word[MW*i +: MW] = q_mark;
        end

        f_found = 1'b0;
        f_pos = '0;
        for (int i = WP - 1; i >= 0; i--) begin
            if (cpba_pkg::WPI_W'(i) >= r_fo
                && ram_rdata[MW*i +: MW] == cpba_pkg::MARK_LAST) begin
                f_found = 1'b1;
                f_pos = cpba_pkg::WPI_W'(i);
            end
        end
        for (int i = 0; i < WP; i++) begin
            if (cpba_pkg::WPI_W'(i) >= r_fo && (!f_found || cpba_pkg::WPI_W'(i) <= f_pos)) begin
                fw_word[MW*i +: MW] = cpba_pkg::MARK_FREE;
            end else begin
                fw_word[MW*i +: MW] = ram_rdata[MW*i +: MW];
            end
        end
        if (f_found) begin
            f_add = {1'b0, f_pos} - {1'b0, r_fo} + 1'b1;
        end else begin
            f_add = (cpba_pkg::WPI_W + 1)'(WP) - {1'b0, r_fo};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_end       = r_end;
        n_resume    = r_resume;
        n_limit     = r_limit;
        n_run       = r_run;
        n_count     = r_count;
        n_base      = r_base;
        n_start     = r_start;
        n_last      = r_last;
        n_pg        = r_pg;
        n_fo        = r_fo;
        n_freed     = r_freed;
        n_res_st    = r_res_st;
        n_res_addr  = r_res_addr;
        n_res_freed = r_res_freed;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_st      = r_m_st;
        n_m_addr    = r_m_addr;
        n_m_freed   = r_m_freed;
        ram_we      = 1'b0;
        ram_wdata   = '0;

        lim_big = (32'(r_limit) >= 32'(WORDS));
        a_end = (r_limit == '0 || lim_big) ? RW_W'(WORDS) : RW_W'(r_limit);
        f_off = s_axis_tdata[76:45] - s_axis_tdata[44:13];
        f_idx = f_off >> PAGE_SHIFT;
        f_mark = ram_rdata[MW*r_fo +: MW];
        fo_m1 = r_fo - 1'b1;
        f_prev = ram_rdata[MW*fo_m1 +: MW];

        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_w == RW_W'(WORDS - 1)) begin
                    n_w = '0;
                    n_state = S_IDLE;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_count = s_axis_tdata[12:0];
                    n_base  = s_axis_tdata[44:13];
                    n_res_addr = '0;
                    n_res_freed = '0;
                    if (s_axis_tuser == cpba_pkg::REQ_ALLOC) begin
                        if (s_axis_tdata[12:0] == '0 || r_resume >= a_end) begin
                            n_resume = '0;
                            n_res_st = cpba_pkg::ST_NOSPACE;
                            n_state = S_PUSH;
                        end else begin
                            n_w = r_resume;
                            n_run = '0;
                            n_end = a_end;
                            n_state = S_A_RD;
                        end
                    end else begin
                        if (f_idx >= 32'(STORE_PAGES)) begin
                            n_res_st = cpba_pkg::ST_BADPTR;
                            n_state = S_PUSH;
                        end else begin
                            n_pg = f_idx[PG_W-1:0];
                            n_w = RW_W'(f_idx[PG_W-1:cpba_pkg::WPI_W]);
                            n_fo = f_idx[cpba_pkg::WPI_W-1:0];
                            n_freed = '0;
                            n_state = S_F_RD0;
                        end
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_EV;
            end
            S_A_EV: begin
                if (a_hit) begin
                    n_last = {r_w[WA_W-1:0], a_pos};
                    n_start = PG_W'(32'(n_last) - 32'(r_count) + 32'd1);
                    n_resume = r_w + RW_W'(a_pos == cpba_pkg::WPI_W'(WP - 1));
                    n_w = RW_W'(n_start[PG_W-1:cpba_pkg::WPI_W]);
                    n_state = S_M_RD;
                end else begin
                    n_run = a_run;
                    if (r_w + 1'b1 == r_end) begin
                        n_resume = '0;
                        n_res_st = cpba_pkg::ST_NOSPACE;
                        n_state = S_PUSH;
                    end else begin
                        n_w = r_w + 1'b1;
                        n_state = S_A_RD;
                    end
                end
            end
            S_M_RD: begin
                n_state = S_M_WR;
            end
            S_M_WR: begin
                ram_we = 1'b1;
                ram_wdata = mk_word;
                if (r_w[WA_W-1:0] == r_last[PG_W-1:cpba_pkg::WPI_W]) begin
                    n_res_st = cpba_pkg::ST_OK;
                    n_res_addr = r_base + (32'(r_start) << PAGE_SHIFT);
                    n_state = S_PUSH;
                end else begin
                    n_w = r_w + 1'b1;
                    n_state = S_M_RD;
                end
            end
            S_F_RD0: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (f_mark == cpba_pkg::MARK_FREE || f_mark == cpba_pkg::MARK_INSIDE) begin
                    n_res_st = cpba_pkg::ST_BADPTR;
                    n_state = S_PUSH;
                end else if (f_mark == cpba_pkg::MARK_LAST && r_pg != '0) begin
                    if (r_fo != '0) begin
                        if (f_prev == cpba_pkg::MARK_FIRST
                            || f_prev == cpba_pkg::MARK_INSIDE) begin
                            n_res_st = cpba_pkg::ST_BADPTR;
                            n_state = S_PUSH;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end else begin
                        n_w = r_w - 1'b1;
                        n_state = S_F_PRD;
                    end
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_F_PRD: begin
                n_state = S_F_PEV;
            end
            S_F_PEV: begin
                if (ram_rdata[MW*(WP-1) +: MW] == cpba_pkg::MARK_FIRST
                    || ram_rdata[MW*(WP-1) +: MW] == cpba_pkg::MARK_INSIDE) begin
                    n_res_st = cpba_pkg::ST_BADPTR;
                    n_state = S_PUSH;
                end else begin
                    n_w = RW_W'(r_pg[PG_W-1:cpba_pkg::WPI_W]);
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                n_state = S_F_WR;
            end
            S_F_WR: begin
                ram_we = 1'b1;
                ram_wdata = fw_word;
                n_freed = r_freed + cpba_pkg::COUNT_W'(f_add);
                if (f_found) begin
                    n_res_st = cpba_pkg::ST_OK;
                    n_res_freed = n_freed;
                    n_state = S_PUSH;
                end else if (r_w == RW_W'(WORDS - 1)) begin
                    n_res_st = cpba_pkg::ST_BADPTR;
                    n_state = S_PUSH;
                end else begin
                    n_w = r_w + 1'b1;
                    n_fo = '0;
                    n_state = S_F_RD;
                end
            end
            S_PUSH: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_st = r_res_st;
                    n_m_addr = r_res_addr;
                    n_m_freed = r_res_freed;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_w       <= '0;
            r_resume  <= '0;
            r_limit   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_w       <= n_w;
            r_resume  <= n_resume;
            r_limit   <= n_limit;
            r_m_valid <= n_m_valid;
        end
        r_end       <= n_end;
        r_run       <= n_run;
        r_count     <= n_count;
        r_base      <= n_base;
        r_start     <= n_start;
        r_last      <= n_last;
        r_pg        <= n_pg;
        r_fo        <= n_fo;
        r_freed     <= n_freed;
        r_res_st    <= n_res_st;
        r_res_addr  <= n_res_addr;
        r_res_freed <= n_res_freed;
        r_m_st      <= n_m_st;
        r_m_addr    <= n_m_addr;
        r_m_freed   <= n_m_freed;
    end

    a_resume_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_resume) <= 32'(WORDS))
        else $error("Resume word points past the page store.");

    a_load_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && (!r_m_valid || m_axis_tready)) |=>
        (r_m_valid && r_state == S_IDLE))
        else $error("Finished result was not loaded into the output register.");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("Request accepted while the page store is being cleared.");

    a_fail_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_st != cpba_pkg::ST_OK) |-> (r_m_addr == '0 && r_m_freed == '0))
        else $error("Failed request carries a nonzero address or page count.");

endmodule

`default_nettype wire

// ===== sim/contiguous_page_bitmap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator testbench
// Drives allocate and free requests through the request stream and checks
// every result beat against a software copy of the page mark store.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_tb;

    localparam int WORDS = cpba_pkg::PAGES_DEF / cpba_pkg::WORD_PAGES;

    typedef struct packed {
        logic                         kind;
        logic [cpba_pkg::COUNT_W-1:0] pages;
        logic [cpba_pkg::ADDR_W-1:0]  base;
        logic [cpba_pkg::ADDR_W-1:0]  ptr;
    } t_page_req;

    typedef struct packed {
        cpba_pkg::t_status            status;
        logic [cpba_pkg::ADDR_W-1:0]  addr;
        logic [cpba_pkg::COUNT_W-1:0] freed;
    } t_page_res;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } t_live_run;

    class page_run_scoreboard;
        cpba_pkg::t_mark marks [cpba_pkg::PAGES_DEF];
        int unsigned     resume_word;
        int unsigned     limit_words;
        t_page_res       pending_results [$];
        int              failures;

        function new();
            foreach (marks[i]) marks[i] = cpba_pkg::MARK_FREE;
            resume_word = 0;
            limit_words = 0;
            failures    = 0;
        endfunction

        function void set_limit(logic [cpba_pkg::LIMIT_W-1:0] value);
            limit_words = value;
        endfunction

        function t_page_res reserve_run(logic [cpba_pkg::COUNT_W-1:0] pages,
                                        logic [cpba_pkg::ADDR_W-1:0] base);
            int unsigned stop_word, run_len, first, p, q;
            t_page_res   res;
            res = '{status: cpba_pkg::ST_NOSPACE, addr: '0, freed: '0};
            stop_word = (limit_words == 0) ? WORDS : limit_words;
            if (stop_word > WORDS) stop_word = WORDS;
            run_len = 0;
            first   = 0;
            if (pages != 0 && resume_word < stop_word) begin
                for (p = resume_word * cpba_pkg::WORD_PAGES;
                     p < stop_word * cpba_pkg::WORD_PAGES; p++) begin
                    if (marks[p] != cpba_pkg::MARK_FREE) begin
                        run_len = 0;
                    end else begin
                        if (run_len == 0) first = p;
                        run_len++;
                        if (run_len == pages) begin
                            for (q = first; q <= p; q++) begin
                                marks[q] = (q == p) ? cpba_pkg::MARK_LAST :
                                           (q == first) ? cpba_pkg::MARK_FIRST :
                                           cpba_pkg::MARK_INSIDE;
                            end
                            resume_word = p / cpba_pkg::WORD_PAGES +
                                ((p % cpba_pkg::WORD_PAGES == cpba_pkg::WORD_PAGES - 1)
                                 ? 1 : 0);
                            res.status = cpba_pkg::ST_OK;
                            res.addr   = base + (first << cpba_pkg::PAGE_SHIFT_DEF);
                            return res;
                        end
                    end
                end
            end
            resume_word = 0;
            return res;
        endfunction

        function t_page_res release_run(logic [cpba_pkg::ADDR_W-1:0] base,
                                        logic [cpba_pkg::ADDR_W-1:0] ptr);
            logic [cpba_pkg::ADDR_W-1:0] offset;
            int unsigned                 idx, released;
            cpba_pkg::t_mark             m;
            t_page_res                   res;
            res      = '{status: cpba_pkg::ST_BADPTR, addr: '0, freed: '0};
            offset   = ptr - base;
            idx      = offset >> cpba_pkg::PAGE_SHIFT_DEF;
            released = 0;
            if (idx >= cpba_pkg::PAGES_DEF) return res;
            m = marks[idx];
            if (m == cpba_pkg::MARK_FREE || m == cpba_pkg::MARK_INSIDE) return res;
            if (m == cpba_pkg::MARK_LAST && idx > 0 &&
                (marks[idx-1] == cpba_pkg::MARK_FIRST ||
                 marks[idx-1] == cpba_pkg::MARK_INSIDE)) return res;
            while (idx < cpba_pkg::PAGES_DEF) begin
                m = marks[idx];
                marks[idx] = cpba_pkg::MARK_FREE;
                released++;
                if (m == cpba_pkg::MARK_LAST) begin
                    res.status = cpba_pkg::ST_OK;
                    res.freed  = cpba_pkg::COUNT_W'(released);
                    return res;
                end
                idx++;
            end
            return res;
        endfunction

        function t_page_res note_request(t_page_req r);
            t_page_res res;
            if (r.kind == cpba_pkg::REQ_ALLOC) res = reserve_run(r.pages, r.base);
            else res = release_run(r.base, r.ptr);
            pending_results.push_back(res);
            return res;
        endfunction

        function void check_result(logic [cpba_pkg::OUT_DATA_W-1:0] data,
                                   cpba_pkg::t_status status);
            t_page_res want, got;
            got.status = status;
            got.addr   = data[cpba_pkg::ADDR_W-1:0];
            got.freed  = data[cpba_pkg::ADDR_W +: cpba_pkg::COUNT_W];
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: status %0d addr %h freed %0d",
                             got.status, got.addr, got.freed);
                return;
            end
            want = pending_results.pop_front();
            if (got != want) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: status %0d/%0d addr %h/%h freed %0d/%0d (expected/actual)",
                             want.status, got.status, want.addr, got.addr, want.freed, got.freed);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [cpba_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [cpba_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [cpba_pkg::STATUS_W-1:0]   m_axis_tuser;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [cpba_pkg::LIMIT_W-1:0]    i_cfg_data;

    page_run_scoreboard book = new();
    t_live_run          live_runs [$];
    int unsigned        live_pages   = 0;
    int unsigned        burst_left   = 0;
    int unsigned        results_seen = 0;
    int unsigned        hold_left    = 0;

    contiguous_page_bitmap_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_page_req make_request(logic kind,
                                               logic [cpba_pkg::COUNT_W-1:0] pages,
                                               logic [cpba_pkg::ADDR_W-1:0] base,
                                               logic [cpba_pkg::ADDR_W-1:0] ptr);
        t_page_req r;
        r.kind  = kind;
        r.pages = pages;
        r.base  = base;
        r.ptr   = ptr;
        return r;
    endfunction

    function automatic t_page_req random_request();
        t_page_req   r;
        t_live_run   lr;
        int unsigned sel, page, free_weight;
        r.kind  = cpba_pkg::REQ_ALLOC;
        r.pages = '0;
        r.ptr   = $urandom;
        sel = $urandom_range(99);
        r.base = (sel < 10) ? '0 : (sel < 20) ? '1 : cpba_pkg::ADDR_W'($urandom);
        free_weight = (live_runs.size() == 0) ? 10 : (live_pages > 2500) ? 70 : 45;
        if ($urandom_range(99) >= free_weight) begin
            sel = $urandom_range(99);
            if (sel < 3) r.pages = '0;
            else if (sel < 70) r.pages = cpba_pkg::COUNT_W'($urandom_range(16, 1));
            else if (sel < 92) r.pages = cpba_pkg::COUNT_W'($urandom_range(128, 17));
            else if (sel < 99) r.pages = cpba_pkg::COUNT_W'($urandom_range(1024, 129));
            else r.pages = cpba_pkg::COUNT_W'($urandom_range(cpba_pkg::PAGES_DEF, 1025));
            return r;
        end
        r.kind = cpba_pkg::REQ_FREE;
        sel  = $urandom_range(99);
        page = $urandom_range(cpba_pkg::PAGES_DEF - 1);
        if (live_runs.size() != 0) begin
            lr = live_runs[$urandom_range(live_runs.size() - 1)];
            if (sel < 65) page = lr.first;
            else if (sel < 75 && lr.len > 1) page = lr.first + $urandom_range(lr.len - 1, 1);
        end
        if (sel < 85 || live_runs.size() == 0 && sel < 90)
            r.ptr = r.base + (page << cpba_pkg::PAGE_SHIFT_DEF)
                    + cpba_pkg::ADDR_W'($urandom_range(4095));
        else if (sel < 93)
            r.ptr = r.base + cpba_pkg::ADDR_W'($urandom_range(32'hFFFF_FFFF, 32'h0100_0000));
        return r;
    endfunction

    task automatic send_request(input t_page_req r);
        t_page_res   res;
        int unsigned idx;
        int          k;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = cpba_pkg::IN_DATA_W'({r.ptr, r.base, r.pages});
        s_axis_tuser  = r.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = book.note_request(r);
        if (r.kind == cpba_pkg::REQ_ALLOC && res.status == cpba_pkg::ST_OK) begin
            idx = (res.addr - r.base) >> cpba_pkg::PAGE_SHIFT_DEF;
            live_runs.push_back('{first: idx, len: r.pages});
            live_pages += r.pages;
        end else if (r.kind == cpba_pkg::REQ_FREE && res.status == cpba_pkg::ST_OK) begin
            idx = (r.ptr - r.base) >> cpba_pkg::PAGE_SHIFT_DEF;
            for (k = 0; k < live_runs.size(); k++) begin
                if (live_runs[k].first == idx) begin
                    live_pages -= live_runs[k].len;
                    live_runs.delete(k);
                    break;
                end
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(7)) @(negedge i_clk);
            burst_left = ($urandom_range(9) == 0) ? 80 : $urandom_range(20, 1);
        end
    endtask

    task automatic write_limit(input logic [cpba_pkg::LIMIT_W-1:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (book.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        book.set_limit(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            book.check_result(m_axis_tdata, m_axis_tuser);
            results_seen++;
        end
    end

    // The receiver cycles through always ready, random stalls and a sparse
    // ready pattern, and once holds off long enough to back up the input.
    initial begin
        int unsigned rx_cycle;
        bit          held;
        rx_cycle      = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (!held && results_seen >= 150) begin
                held          = 1'b1;
                hold_left     = 1500;
                m_axis_tready = 1'b0;
            end else begin
                case ((rx_cycle / 256) % 3)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(1));
                    default: m_axis_tready = (rx_cycle % 5 == 0);
                endcase
            end
        end
    end

    initial begin
        int unsigned phase_limits [8];
        int unsigned ph, n;
        phase_limits  = '{256, 1, 12, 0, 255, 3, 64, 0};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = cpba_pkg::REQ_ALLOC;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_limit(0);
        send_request(make_request(cpba_pkg::REQ_ALLOC, 0, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 1, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 1, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0000_1000));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 3, 32'hFFFF_FFFF, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 5, 32'hFFFF_F000, 32'h0));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0000_1000));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0000_2ABC));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0000_8000));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0100_0000));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0000_1000, 32'h0));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'hFFFF_FFFF));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'hFFFF_FFFF, 32'h0000_0FFE));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'hFFFF_F000, 32'h0000_2FFF));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 16, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 1, 32'h8000_0000, 32'h0));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0, 32'h0001_0000));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 4096, 32'h0000_1234, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 4096, 32'h0000_1234, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 1, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_ALLOC, 1, 32'h0, 32'h0));
        send_request(make_request(cpba_pkg::REQ_FREE, 0, 32'h0000_1234, 32'h0000_1234));

        for (ph = 0; ph < 8; ph++) begin
            write_limit(cpba_pkg::LIMIT_W'(phase_limits[ph]));
            for (n = 0; n < 75; n++) send_request(random_request());
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (book.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (book.pending_results.size() != 0) book.failures++;
        if (book.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cpba_pkg.sv
design/cpba_ram.sv
design/contiguous_page_bitmap_allocator.sv
sim/contiguous_page_bitmap_allocator_tb.sv
